### rtl/olae_pkg.sv
// Shared types and constants for the ordered array list engine.
// Used by the controller, the datapath and the top level. No dependencies.
package olae_pkg;

	localparam int DEPTH    = 128;
	localparam int KEY_BITS = 64;
	localparam int WORD_W   = 64;
	localparam int ADDR_W   = $clog2(DEPTH);
	localparam int CNT_W    = $clog2(DEPTH + 1);
	localparam int OP_W     = 2;
	localparam int POS_W    = 8;
	localparam int CAP_W    = 8;
	localparam int STATUS_W = 2;
	localparam int FOUND_W  = 7;
	localparam int ECNT_W   = 8;
	localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(128);

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_FIND   = 2'd2
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_RANGE     = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef struct packed {
		logic [KEY_BITS-1:0] key;
		logic [WORD_W-1:0]   author;
		logic [WORD_W-1:0]   code;
	} record_t;

	// controller -> datapath
	typedef struct packed {
		logic              load;
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic              wr_item;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic key_match;
	} dp_sts_t;

endpackage

### rtl/olae_datapath.sv
// Record store and operand registers of the list engine.
// One write port, one registered read port; key compare on read data. Uses olae_pkg.
module olae_datapath import olae_pkg::*; (
	input  logic                clk,
	input  dp_cmd_t             cmd,
	input  logic [WORD_W-1:0]   entry_key,
	input  logic [WORD_W-1:0]   entry_author,
	input  logic [WORD_W-1:0]   entry_code,
	output dp_sts_t             sts
);

	record_t mem [DEPTH];
	record_t item_q;
	record_t rd_data_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q.key    <= entry_key[KEY_BITS-1:0];
			item_q.author <= entry_author;
			item_q.code   <= entry_code;
		end
	end

	// shift moves use the word read the cycle before
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[cmd.wr_addr] <= cmd.wr_item ? item_q : rd_data_q;
		end
		if (cmd.rd_en) begin
			rd_data_q <= mem[cmd.rd_addr];
		end
	end

	assign sts.key_match = (rd_data_q.key == item_q.key);

endmodule

### rtl/olae_ctrl.sv
// Sequencer of the list engine: checks, shift and scan walks, result register.
// Drives the datapath through dp_cmd_t. Uses olae_pkg.
module olae_ctrl import olae_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [OP_W-1:0]     opcode,
	input  logic [POS_W-1:0]    position,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [STATUS_W-1:0] status,
	output logic [FOUND_W-1:0]  found_position,
	output logic [ECNT_W-1:0]   entry_count,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CAP_W-1:0]    cfg_data,
	output dp_cmd_t             cmd,
	input  dp_sts_t             sts
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_INS_SHIFT,
		S_INS_DRAIN,
		S_INS_PUT,
		S_REM_SHIFT,
		S_REM_DRAIN,
		S_FIND,
		S_FIND_LAST,
		S_DONE
	} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    count_q;
	logic [CAP_W-1:0]    capacity_q;
	logic [ADDR_W-1:0]   idx_q;
	logic [ADDR_W-1:0]   pos_q;
	logic                pend_q;
	logic [ADDR_W-1:0]   pend_addr_q;
	status_t             res_status_q;
	logic [ADDR_W-1:0]   res_found_q;
	logic                out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [FOUND_W-1:0]  out_found_q;
	logic [ECNT_W-1:0]   out_count_q;

	logic                accept;
	logic [CMP_W-1:0]    pos_ext;
	logic [CMP_W-1:0]    cnt_ext;
	logic [CMP_W-1:0]    cap_ext;
	logic [CMP_W-1:0]    limit;
	logic                idx_is_last;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;

	assign pos_ext = CMP_W'(position);
	assign cnt_ext = CMP_W'(count_q);
	assign cap_ext = CMP_W'(capacity_q);
	assign limit   = (cap_ext < CMP_W'(DEPTH)) ? cap_ext : CMP_W'(DEPTH);

	// last element of an upward walk (remove, find)
	assign idx_is_last = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);

	always_comb begin
		cmd         = '0;
		cmd.load    = accept;
		cmd.rd_addr = idx_q;
		cmd.wr_addr = pend_addr_q;
		case (state_q)
			S_INS_SHIFT, S_REM_SHIFT: begin
				cmd.rd_en = 1'b1;
				cmd.wr_en = pend_q;
			end
			S_INS_DRAIN, S_REM_DRAIN: begin
				cmd.wr_en = pend_q;
			end
			S_INS_PUT: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_item = 1'b1;
				cmd.wr_addr = pos_q;
			end
			S_FIND: begin
				cmd.rd_en = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			capacity_q   <= CAP_RESET;
			idx_q        <= '0;
			pos_q        <= '0;
			pend_q       <= 1'b0;
			pend_addr_q  <= '0;
			res_status_q <= ST_OK;
			res_found_q  <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= '0;
			out_found_q  <= '0;
			out_count_q  <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				capacity_q <= cfg_data;
			end
			// DONE reloads the slot itself
			if (out_valid_q && !out_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						pend_q       <= 1'b0;
						res_status_q <= ST_OK;
						res_found_q  <= '0;
						pos_q        <= ADDR_W'(position);
						case (opcode)
							OP_INSERT: begin
								if (pos_ext > cnt_ext) begin
									res_status_q <= ST_RANGE;
									state_q      <= S_DONE;
								end else if (cnt_ext >= limit) begin
									res_status_q <= ST_FULL;
									state_q      <= S_DONE;
								end else if (pos_ext == cnt_ext) begin
									state_q <= S_INS_PUT;
								end else begin
									idx_q   <= ADDR_W'(count_q - CNT_W'(1));
									state_q <= S_INS_SHIFT;
								end
							end
							OP_REMOVE: begin
								if (pos_ext >= cnt_ext) begin
									res_status_q <= ST_RANGE;
									state_q      <= S_DONE;
								end else if ((pos_ext + CMP_W'(1)) == cnt_ext) begin
									state_q <= S_REM_DRAIN;
								end else begin
									idx_q   <= ADDR_W'(position) + ADDR_W'(1);
									state_q <= S_REM_SHIFT;
								end
							end
							OP_FIND: begin
								if (count_q == '0) begin
									res_status_q <= ST_NOT_FOUND;
									state_q      <= S_DONE;
								end else begin
									idx_q   <= '0;
									state_q <= S_FIND;
								end
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_INS_SHIFT: begin
					// read idx now, write it one slot up next cycle
					pend_q      <= 1'b1;
					pend_addr_q <= idx_q + ADDR_W'(1);
					if (idx_q == pos_q) begin
						state_q <= S_INS_DRAIN;
					end else begin
						idx_q <= idx_q - ADDR_W'(1);
					end
				end
				S_INS_DRAIN: begin
					pend_q  <= 1'b0;
					state_q <= S_INS_PUT;
				end
				S_INS_PUT: begin
					count_q <= count_q + CNT_W'(1);
					state_q <= S_DONE;
				end
				S_REM_SHIFT: begin
					pend_q      <= 1'b1;
					pend_addr_q <= idx_q - ADDR_W'(1);
					if (idx_is_last) begin
						state_q <= S_REM_DRAIN;
					end else begin
						idx_q <= idx_q + ADDR_W'(1);
					end
				end
				S_REM_DRAIN: begin
					pend_q  <= 1'b0;
					count_q <= count_q - CNT_W'(1);
					state_q <= S_DONE;
				end
				S_FIND: begin
					// pend marks valid read data from the previous cycle
					pend_q      <= 1'b1;
					pend_addr_q <= idx_q;
					if (pend_q && sts.key_match) begin
						res_found_q <= pend_addr_q;
						state_q     <= S_DONE;
					end else if (idx_is_last) begin
						state_q <= S_FIND_LAST;
					end else begin
						idx_q <= idx_q + ADDR_W'(1);
					end
				end
				S_FIND_LAST: begin
					pend_q <= 1'b0;
					if (sts.key_match) begin
						res_found_q <= pend_addr_q;
					end else begin
						res_status_q <= ST_NOT_FOUND;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_found_q  <= FOUND_W'(res_found_q);
						out_count_q  <= ECNT_W'(count_q);
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = out_status_q;
	assign found_position = out_found_q;
	assign entry_count    = out_count_q;

endmodule

### rtl/ordered_array_list_engine_core.sv
// Ordered record list engine: top level.
// Instantiates olae_ctrl and olae_datapath. Uses olae_pkg.
//
// Usage:
//   Input channel (in_valid/in_stall) carries opcode, position and one record
//   (entry_key, entry_author, entry_code). Opcodes: insert at position, remove
//   at position, find by key. Every transfer yields one result on the output
//   channel (out_valid/out_stall): status, found_position, entry_count.
//   The cfg channel (cfg_valid/cfg_ready, always ready) sets the capacity
//   limit; write it only while no operation is in flight.
// Sequencing:
//   One operation at a time. A walk over the record store moves one entry per
//   cycle through the single-port-read/single-port-write memory:
//     insert  walk from the last entry down to position, then put the record
//     remove  walk from position + 1 up to the last entry, then drain
//     find    scan from entry 0 up to the first match or the last entry
//   Tail inserts/removes skip the walk; rejected or unknown ops go to the result.
//   in_stall is high while an operation runs; a result held by out_stall does
//   not block the next transfer in, but its completion waits for the slot.
// Reset: count cleared, capacity set to 128, output empty; the record store
//   is not cleared (entries above the count are never read).
module ordered_array_list_engine_core import olae_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [OP_W-1:0]     opcode,
	input  logic [POS_W-1:0]    position,
	input  logic [WORD_W-1:0]   entry_key,
	input  logic [WORD_W-1:0]   entry_author,
	input  logic [WORD_W-1:0]   entry_code,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [STATUS_W-1:0] status,
	output logic [FOUND_W-1:0]  found_position,
	output logic [ECNT_W-1:0]   entry_count,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CAP_W-1:0]    cfg_data
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	olae_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.opcode         (opcode),
		.position       (position),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.found_position (found_position),
		.entry_count    (entry_count),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.cmd            (cmd),
		.sts            (sts)
	);

	olae_datapath u_dp (
		.clk          (clk),
		.cmd          (cmd),
		.entry_key    (entry_key),
		.entry_author (entry_author),
		.entry_code   (entry_code),
		.sts          (sts)
	);

endmodule

### rtl/olae_checker.sv
// Port-level checks for the list engine top level, attached by bind.
// Uses olae_pkg.
module olae_checker import olae_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input logic [STATUS_W-1:0] status,
	input logic [FOUND_W-1:0]  found_position,
	input logic [ECNT_W-1:0]   entry_count
);

	// held result stays up
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(status) && $stable(entry_count))
		else $error("stalled result changed");

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("engine not busy after an input transfer");

	a_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> found_position == '0)
		else $error("found_position set on a failed operation");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> entry_count <= ECNT_W'(DEPTH))
		else $error("entry_count beyond store depth");

endmodule

bind ordered_array_list_engine_core olae_checker u_olae_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.status         (status),
	.found_position (found_position),
	.entry_count    (entry_count)
);

### tb/ordered_array_list_engine_core_test.sv
`timescale 1ns / 1ps
// Self-checking bench for ordered_array_list_engine_core: directed and random insert,
// remove and find traffic with random valid/stall gaps across several capacity settings.
// Depends on olae_pkg and the core RTL only.
module ordered_array_list_engine_core_test;
	import olae_pkg::*;

	localparam int unsigned CYCLE_LIMIT     = 2_000_000;
	localparam int          DRAIN_CYCLES    = 140;
	localparam int          HOLD_OFF_CYCLES = 400;
	localparam logic [WORD_W-1:0] ONES  = '1;
	localparam logic [WORD_W-1:0] ALT_A = {32{2'b10}};
	localparam logic [WORD_W-1:0] ALT_5 = {32{2'b01}};
	localparam logic [WORD_W-1:0] EDGES = {1'b1, 62'd0, 1'b1};
	localparam logic [OP_W-1:0]   OP_SPARE = 2'd3; // not decoded by the block

	typedef struct {
		logic [STATUS_W-1:0] st;
		logic [FOUND_W-1:0]  found;
		logic [ECNT_W-1:0]   cnt;
	} reply_t;

	// Mirror of the record list: only keys matter for the result fields.
	class list_tracker;
		logic [KEY_BITS-1:0] keys[DEPTH];
		int unsigned         count;
		int unsigned         capacity;
		int unsigned         peak;
		reply_t              due[$];
		int                  errors;
		int                  replies;
		int                  op_tally[4];
		int                  st_tally[4];

		function new();
			count = 0;
			capacity = CAP_RESET;
			peak = 0;
			errors = 0;
			replies = 0;
			foreach (op_tally[i]) begin
				op_tally[i] = 0;
				st_tally[i] = 0;
			end
		endfunction

		function void log_op(logic [OP_W-1:0] op, int unsigned pos, logic [WORD_W-1:0] key);
			reply_t              r;
			int unsigned         lim;
			int unsigned         i;
			logic [KEY_BITS-1:0] k;
			k = key[KEY_BITS-1:0];
			lim = (capacity < DEPTH) ? capacity : DEPTH;
			r.st = ST_OK;
			r.found = '0;
			case (op)
			OP_INSERT: begin
				// position is tested before fullness
				if (pos > count)
					r.st = ST_RANGE;
				else if (count >= lim)
					r.st = ST_FULL;
				else begin
					for (i = count; i > pos; i--)
						keys[i] = keys[i-1];
					keys[pos] = k;
					count++;
				end
			end
			OP_REMOVE: begin
				if (pos >= count)
					r.st = ST_RANGE;
				else begin
					for (i = pos + 1; i < count; i++)
						keys[i-1] = keys[i];
					count--;
				end
			end
			OP_FIND: begin
				r.st = ST_NOT_FOUND;
				for (i = 0; i < count; i++) begin
					if (r.st == ST_NOT_FOUND && keys[i] == k) begin
						r.st = ST_OK;
						r.found = FOUND_W'(i);
					end
				end
			end
			default: ; // unused opcode: ok, nothing changes
			endcase
			r.cnt = ECNT_W'(count);
			if (count > peak)
				peak = count;
			op_tally[op]++;
			st_tally[r.st]++;
			due.push_back(r);
		endfunction

		function void check_reply(logic [STATUS_W-1:0] st, logic [FOUND_W-1:0] found,
				logic [ECNT_W-1:0] cnt);
			reply_t r;
			if (due.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: unexpected result st=%0d pos=%0d cnt=%0d",
						$time, st, found, cnt);
				return;
			end
			r = due.pop_front();
			replies++;
			if (st !== r.st || found !== r.found || cnt !== r.cnt) begin
				errors++;
				if (errors <= 10)
					$display("%0t: mismatch exp st=%0d pos=%0d cnt=%0d got st=%0d pos=%0d cnt=%0d",
						$time, r.st, r.found, r.cnt, st, found, cnt);
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [OP_W-1:0]     opcode = '0;
	logic [POS_W-1:0]    position = '0;
	logic [WORD_W-1:0]   entry_key = '0;
	logic [WORD_W-1:0]   entry_author = '0;
	logic [WORD_W-1:0]   entry_code = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [FOUND_W-1:0]  found_position;
	logic [ECNT_W-1:0]   entry_count;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [CAP_W-1:0]    cfg_data = '0;

	list_tracker       tracker = new();
	logic [WORD_W-1:0] key_pool[16];
	int                send_run = 0;
	int                recv_run = 0;
	bit                hold_off_req = 1'b0;
	int unsigned       items_sent = 0;
	int unsigned       cap_settings = 0;
	int unsigned       cycle_count = 0;

	ordered_array_list_engine_core i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.opcode         (opcode),
		.position       (position),
		.entry_key      (entry_key),
		.entry_author   (entry_author),
		.entry_code     (entry_code),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.found_position (found_position),
		.entry_count    (entry_count),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, tracker.due.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	// Random wait before a transfer, with occasional runs of back-to-back items.
	function automatic int draw_wait(inout int run_left);
		if (run_left > 0) begin
			run_left--;
			return 0;
		end
		if ($urandom_range(0, 29) == 0)
			run_left = $urandom_range(10, 40);
		return $urandom_range(0, 15);
	endfunction

	task automatic send_op(logic [OP_W-1:0] op, logic [POS_W-1:0] pos, logic [WORD_W-1:0] key,
			logic [WORD_W-1:0] author, logic [WORD_W-1:0] code);
		int gap;
		gap = draw_wait(send_run);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		opcode       <= op;
		position     <= pos;
		entry_key    <= key;
		entry_author <= author;
		entry_code   <= code;
		do @(posedge clk); while (in_stall);
		tracker.log_op(op, pos, key);
		items_sent++;
	endtask

	task automatic send_random(int ins_pct, int rem_pct);
		int unsigned       fill;
		int unsigned       roll;
		logic [OP_W-1:0]   op;
		logic [POS_W-1:0]  pos;
		logic [WORD_W-1:0] key;
		fill = tracker.count;
		roll = $urandom_range(0, 99);
		if (roll < ins_pct)
			op = OP_INSERT;
		else if (roll < ins_pct + rem_pct)
			op = OP_REMOVE;
		else if (roll < 97)
			op = OP_FIND;
		else
			op = OP_SPARE;
		// mostly legal positions, the rest anywhere from the end up to 255
		if ($urandom_range(0, 99) < 85 && (op == OP_INSERT || fill > 0))
			pos = (op == OP_INSERT) ? POS_W'($urandom_range(0, fill))
				: POS_W'($urandom_range(0, fill - 1));
		else
			pos = POS_W'($urandom_range(fill, 255));
		// pooled keys give duplicates, so finds must pick the lowest match
		case ($urandom_range(0, 3))
		0, 1: begin
			if (op == OP_FIND && fill > 0)
				key = tracker.keys[$urandom_range(0, fill - 1)];
			else
				key = key_pool[$urandom_range(0, 15)];
		end
		2: key = key_pool[$urandom_range(0, 15)];
		default: key = {$urandom, $urandom};
		endcase
		send_op(op, pos, key, {$urandom, $urandom}, {$urandom, $urandom});
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (tracker.due.size() != 0) @(posedge clk);
	endtask

	task automatic write_capacity(int unsigned cap);
		drain();
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= CAP_W'(cap);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		tracker.capacity = cap;
		cap_settings++;
	endtask

	task automatic run_phase(int unsigned cap, int n, int ins_pct, int rem_pct, bit hold);
		write_capacity(cap);
		hold_off_req = hold;
		repeat (n) send_random(ins_pct, rem_pct);
	endtask

	initial begin : result_sink
		int stall_len;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				stall_len = HOLD_OFF_CYCLES;
			end else
				stall_len = draw_wait(recv_run);
			if (stall_len > 0) begin
				out_stall <= 1'b1;
				repeat (stall_len) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			tracker.check_reply(status, found_position, entry_count);
		end
	end

	initial begin : stimulus
		foreach (key_pool[i])
			key_pool[i] = {$urandom, $urandom};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty list, edge positions, duplicates, extreme words
		send_op(OP_REMOVE, 8'd0, ONES, '0, '0);
		send_op(OP_FIND, 8'd0, ONES, '0, '0);
		send_op(OP_SPARE, 8'd255, ONES, ONES, ONES);
		send_op(OP_INSERT, 8'd1, ONES, ONES, ONES);
		send_op(OP_INSERT, 8'd255, ONES, ONES, ONES);
		send_op(OP_INSERT, 8'd0, ONES, '0, ONES);
		send_op(OP_INSERT, 8'd0, '0, ONES, '0);
		send_op(OP_INSERT, 8'd2, ALT_A, ALT_5, ALT_A);
		send_op(OP_INSERT, 8'd1, ALT_5, ALT_A, ALT_5);
		send_op(OP_INSERT, 8'd4, ONES, '0, '0);
		send_op(OP_FIND, 8'd255, ONES, '0, '0);
		send_op(OP_FIND, 8'd0, '0, ONES, ONES);
		send_op(OP_FIND, 8'd77, ALT_A, '0, '0);
		send_op(OP_FIND, 8'd0, 64'd1, '0, '0);
		send_op(OP_REMOVE, 8'd5, '0, '0, '0);
		send_op(OP_REMOVE, 8'd255, ONES, ONES, ONES);
		send_op(OP_REMOVE, 8'd0, '0, '0, '0);
		send_op(OP_FIND, 8'd0, ONES, '0, '0);
		send_op(OP_REMOVE, 8'd3, '0, '0, '0);
		send_op(OP_REMOVE, 8'd1, '0, '0, '0);
		send_op(OP_SPARE, 8'd0, ALT_5, '0, '0);
		send_op(OP_FIND, 8'd128, ALT_5, '0, '0);
		send_op(OP_INSERT, 8'd2, EDGES, EDGES, EDGES);
		send_op(OP_FIND, 8'd2, EDGES, '0, '0);

		// fill to the top with a long output hold-off, then shrink below the fill
		run_phase(128, 450, 60, 20, 1'b1);
		run_phase(40, 300, 25, 55, 1'b0);
		run_phase(0, 120, 40, 40, 1'b0);
		run_phase(255, 400, 45, 35, 1'b0);
		run_phase($urandom_range(1, 20), 250, 50, 30, 1'b0);
		run_phase(1, 100, 45, 35, 1'b0);

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d ops (%0d insert, %0d remove, %0d find, %0d unused) over %0d capacities,",
			items_sent, tracker.op_tally[OP_INSERT], tracker.op_tally[OP_REMOVE],
			tracker.op_tally[OP_FIND], tracker.op_tally[OP_SPARE], cap_settings);
		$display("peak fill %0d; outcomes ok %0d, range %0d, full %0d, miss %0d; %0d mismatches",
			tracker.peak, tracker.st_tally[ST_OK], tracker.st_tally[ST_RANGE],
			tracker.st_tally[ST_FULL], tracker.st_tally[ST_NOT_FOUND], tracker.errors);
		if (tracker.errors == 0 && tracker.due.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

### sim.f
rtl/olae_pkg.sv
rtl/olae_datapath.sv
rtl/olae_ctrl.sv
rtl/ordered_array_list_engine_core.sv
rtl/olae_checker.sv
tb/ordered_array_list_engine_core_test.sv
